// ----- hw/rtl/balance_robot_motor_control_macros.svh -----
// ----------------------------------------------------------------------------
// Balance robot motor control: assertion macros
// Shared shorthand for concurrent assertions clocked on clock and disabled
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef BALANCE_ROBOT_MOTOR_CONTROL_MACROS_SVH
`define BALANCE_ROBOT_MOTOR_CONTROL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRMC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("brmc: property violated");

// The consequent must hold in the cycle after the antecedent.
`define BRMC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("brmc: property violated");

`endif

// ----- hw/rtl/brmc_pkg.sv -----
// ----------------------------------------------------------------------------
// Balance robot motor control package
// Word types, register indexes, reset values, fixed-point constants and the
// widths of the shared datapath.
// ----------------------------------------------------------------------------
package brmc_pkg;

   // Input and result words.
   typedef struct packed {
      logic signed [16:0] tilt_angle;
      logic signed [15:0] pitch_rate;
      logic signed [15:0] yaw_rate;
      logic signed [15:0] left_count;
      logic signed [15:0] right_count;
   } brmc_req_type;

   typedef struct packed {
      logic [12:0] left_magnitude;
      logic        left_forward;
      logic [12:0] right_magnitude;
      logic        right_forward;
      logic        tilt_fault;
   } brmc_rsp_type;

   // Register port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_BALANCE_KP    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BALANCE_KD    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_KP      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_KI      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_YAW_KD        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BALANCE_POINT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_REQUEST  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_PWM_LIMIT     = 3'd7;

   localparam int GAIN_W  = 16;
   localparam int POINT_W = 13;
   localparam int MAG_W   = 13;

   localparam logic [GAIN_W-1:0]         BALANCE_KP_RESET    = 16'd22500;
   localparam logic [GAIN_W-1:0]         BALANCE_KD_RESET    = 16'd108;
   localparam logic [GAIN_W-1:0]         SPEED_KP_RESET      = 16'd16000;
   localparam logic [GAIN_W-1:0]         SPEED_KI_RESET      = 16'd80;
   localparam logic [GAIN_W-1:0]         YAW_KD_RESET        = 16'd50;
   localparam logic signed [POINT_W-1:0] BALANCE_POINT_RESET = 13'sd0;
   localparam logic [MAG_W-1:0]          PWM_LIMIT_RESET     = 13'd6900;

   // Shared multiplier: signed 27 by signed 17 bits.
   localparam int MUL_A_W = 27;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Working widths.
   localparam int ERR_W   = 18;   // tilt error and speed error
   localparam int FILT_W  = 26;   // filtered speed error, Q8
   localparam int INTEG_W = 24;   // speed integral, Q8
   localparam int ISUM_W  = 27;   // integral before the clamp
   localparam int TERM_W  = 28;   // signed control terms
   localparam int CMD_W   = 30;   // wheel command before saturation

   // Filter weights in Q8: 0.86 is 220/256, 0.14 is 36/256 (times 256 for the
   // Q8 scaling of the new sample).
   localparam logic signed [MUL_B_W-1:0] FILT_KEEP = 17'sd220;
   localparam logic signed [MUL_B_W-1:0] FILT_NEW  = 17'sd9216;
   localparam int                        FILT_SHIFT = 8;

   // Limits: 40 degrees in Q8.8, and 10000 counts in Q8.
   localparam logic signed [16:0]        TILT_LIMIT  = 17'sd10240;
   localparam logic signed [ISUM_W-1:0]  INTEG_LIMIT = 27'sd2560000;

   // Gains are scaled by one hundred; the balance and speed sums carry a
   // further Q8 scale that is removed by a shift before the divide by 100.
   localparam int SCALE_SHIFT = 8;

   // Constant divider: three quotient bits per step, nine steps.
   localparam int                    DIV_RADIX_BITS = 3;
   localparam int                    DIV_STEPS      = 9;
   localparam int                    DIV_QUOT_W     = DIV_RADIX_BITS * DIV_STEPS;
   localparam int                    DIV_NUM_W      = 33;
   localparam int                    DIV_HEAD_W     = DIV_NUM_W - DIV_QUOT_W;
   localparam int                    DIV_REM_W      = 7;
   localparam int                    DIV_CNT_W      = $clog2(DIV_STEPS + 1);
   localparam logic [DIV_REM_W:0]    DIV_DIVISOR    = 8'd100;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
   } brmc_div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIV_QUOT_W-1:0] quot;
   } brmc_div_rsp_type;

endpackage

// ----- hw/rtl/brmc_div.sv -----
// ----------------------------------------------------------------------------
// Balance robot motor control: divide by one hundred
// Multi-cycle restoring divider for unsigned magnitudes, three quotient bits
// per cycle. The quotient is valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module brmc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  brmc_pkg::brmc_div_req_type div_req,
   output brmc_pkg::brmc_div_rsp_type div_rsp
);
   import brmc_pkg::*;

   logic [DIV_REM_W-1:0]  rem_ff;
   logic [DIV_REM_W-1:0]  rem_in;
   logic [DIV_QUOT_W-1:0] qn_ff;
   logic [DIV_QUOT_W-1:0] qn_in;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic                  done_ff;
   logic [DIV_REM_W:0]    trial;

   // Three compare-and-subtract steps. The shift register feeds dividend bits
   // out at the top and takes quotient bits in at the bottom.
   always_comb begin
      rem_in = rem_ff;
      qn_in  = qn_ff;
      trial  = '0;
      for (int k = 0; k < DIV_RADIX_BITS; k++) begin
         trial = {rem_in, qn_in[DIV_QUOT_W-1]};
         if (trial >= DIV_DIVISOR) begin
            rem_in = DIV_REM_W'(trial - DIV_DIVISOR);
            qn_in  = {qn_in[DIV_QUOT_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_REM_W-1:0];
            qn_in  = {qn_in[DIV_QUOT_W-2:0], 1'b0};
         end
      end
   end

   // Step counter and completion flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == DIV_CNT_W'(1));
         if (div_req.start) begin
            cnt_ff <= DIV_CNT_W'(DIV_STEPS);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
         end
      end
   end

   // Remainder and dividend/quotient shift register.
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= DIV_REM_W'(div_req.num[DIV_NUM_W-1 -: DIV_HEAD_W]);
         qn_ff  <= div_req.num[DIV_QUOT_W-1:0];
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         qn_ff  <= qn_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = qn_ff;

endmodule

// ----- hw/rtl/balance_robot_motor_control.sv -----
// ----------------------------------------------------------------------------
// Balance robot motor control
// One control tick per input word: a PD balance term on the tilt error, a PI
// speed term on the low-pass filtered wheel speed error and a D yaw term are
// combined into left and right motor duties, saturated to pwm_limit. The
// block works on one word at a time: the time from acceptance of a word to
// readiness for the next is set by the single shared 27x17 multiplier
// (seven products), by the shared divide-by-100 unit, which is used three
// times, and by any output stall. Each result is held in an
// output register, so the next word is accepted while a result still waits
// to be taken; a new result is only written once the previous one has gone.
// Register writes are expected while the block is idle. A tilt beyond
// 40 degrees or a stop request raises tilt_fault and clears the speed
// integral after it has been used; the motor duties are not forced to zero.
// ----------------------------------------------------------------------------
module balance_robot_motor_control (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  brmc_pkg::brmc_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output brmc_pkg::brmc_rsp_type              rsp_data,
   input  logic                                csr_wr_en,
   input  logic [brmc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [brmc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import brmc_pkg::*;

   // Sequencer states.
   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] ST_IDLE    = 5'd0;
   localparam logic [ST_W-1:0] ST_BAL_MP  = 5'd1;
   localparam logic [ST_W-1:0] ST_BAL_MD  = 5'd2;
   localparam logic [ST_W-1:0] ST_BAL_ADD = 5'd3;
   localparam logic [ST_W-1:0] ST_BAL_GO  = 5'd4;
   localparam logic [ST_W-1:0] ST_BAL_WT  = 5'd5;
   localparam logic [ST_W-1:0] ST_FLT_MK  = 5'd6;
   localparam logic [ST_W-1:0] ST_FLT_ME  = 5'd7;
   localparam logic [ST_W-1:0] ST_FLT_ADD = 5'd8;
   localparam logic [ST_W-1:0] ST_INT     = 5'd9;
   localparam logic [ST_W-1:0] ST_VEL_MP  = 5'd10;
   localparam logic [ST_W-1:0] ST_VEL_MI  = 5'd11;
   localparam logic [ST_W-1:0] ST_VEL_ADD = 5'd12;
   localparam logic [ST_W-1:0] ST_VEL_GO  = 5'd13;
   localparam logic [ST_W-1:0] ST_VEL_WT  = 5'd14;
   localparam logic [ST_W-1:0] ST_YAW_MP  = 5'd15;
   localparam logic [ST_W-1:0] ST_YAW_GO  = 5'd16;
   localparam logic [ST_W-1:0] ST_YAW_WT  = 5'd17;
   localparam logic [ST_W-1:0] ST_OUT     = 5'd18;

   // Configuration registers.
   logic [GAIN_W-1:0]         balance_kp_ff;
   logic [GAIN_W-1:0]         balance_kd_ff;
   logic [GAIN_W-1:0]         speed_kp_ff;
   logic [GAIN_W-1:0]         speed_ki_ff;
   logic [GAIN_W-1:0]         yaw_kd_ff;
   logic signed [POINT_W-1:0] balance_point_ff;
   logic                      stop_request_ff;
   logic [MAG_W-1:0]          pwm_limit_ff;

   // Sequencer and loop state.
   logic [ST_W-1:0]           state_ff;
   logic [ST_W-1:0]           state_in;
   logic signed [FILT_W-1:0]  filt_ff;
   logic signed [INTEG_W-1:0] integ_ff;

   // Captured word.
   logic signed [ERR_W-1:0]   tilt_err_ff;
   logic signed [15:0]        pitch_rate_ff;
   logic signed [15:0]        yaw_rate_ff;
   logic signed [ERR_W-1:0]   speed_err_ff;
   logic                      fault_ff;

   // Shared datapath.
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  acc_ff;
   logic [PROD_W-1:0]         acc_mag;
   logic [PROD_W-1:0]         prod_mag;
   logic signed [PROD_W-1:0]  filt_sum;
   logic signed [ISUM_W-1:0]  integ_sum;
   logic signed [INTEG_W-1:0] integ_in;
   logic                      neg_ff;
   logic signed [TERM_W-1:0]  quot_pos;
   logic signed [TERM_W-1:0]  quot_neg;
   logic signed [TERM_W-1:0]  bal_ff;
   logic signed [TERM_W:0]    bal_vel_ff;
   logic signed [TERM_W-1:0]  yaw_ff;
   logic signed [CMD_W-1:0]   left_cmd;
   logic signed [CMD_W-1:0]   right_cmd;
   logic [MAG_W:0]            left_drive;
   logic [MAG_W:0]            right_drive;

   // Handshake and result register.
   logic                      req_fire;
   logic                      out_fire;
   logic                      rsp_valid_ff;
   brmc_rsp_type              rsp_data_ff;

   brmc_div_req_type          div_req;
   brmc_div_rsp_type          div_rsp;

   // Saturate a wheel command and split it into direction and magnitude.
   function automatic logic [MAG_W:0] drive_word(input logic signed [CMD_W-1:0] cmd,
                                                 input logic [MAG_W-1:0] lim);
      logic signed [CMD_W-1:0] lim_s;
      logic signed [CMD_W-1:0] sat;
      logic signed [CMD_W-1:0] mag;
      lim_s = signed'(CMD_W'(lim));
      if (cmd > lim_s) begin
         sat = lim_s;
      end else if (cmd < -lim_s) begin
         sat = -lim_s;
      end else begin
         sat = cmd;
      end
      mag = sat[CMD_W-1] ? -sat : sat;
      return {(sat > 0), mag[MAG_W-1:0]};
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_fire  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         balance_kp_ff    <= BALANCE_KP_RESET;
         balance_kd_ff    <= BALANCE_KD_RESET;
         speed_kp_ff      <= SPEED_KP_RESET;
         speed_ki_ff      <= SPEED_KI_RESET;
         yaw_kd_ff        <= YAW_KD_RESET;
         balance_point_ff <= BALANCE_POINT_RESET;
         stop_request_ff  <= 1'b0;
         pwm_limit_ff     <= PWM_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BALANCE_KP:    balance_kp_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_BALANCE_KD:    balance_kd_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_SPEED_KP:      speed_kp_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_SPEED_KI:      speed_ki_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_YAW_KD:        yaw_kd_ff        <= csr_wdata[GAIN_W-1:0];
            CSR_BALANCE_POINT: balance_point_ff <= signed'(csr_wdata[POINT_W-1:0]);
            CSR_STOP_REQUEST:  stop_request_ff  <= csr_wdata[0];
            CSR_PWM_LIMIT:     pwm_limit_ff     <= csr_wdata[MAG_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: balance term, filter, integral, speed term, yaw term, output.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_fire) state_in = ST_BAL_MP;
         ST_BAL_MP:  state_in = ST_BAL_MD;
         ST_BAL_MD:  state_in = ST_BAL_ADD;
         ST_BAL_ADD: state_in = ST_BAL_GO;
         ST_BAL_GO:  state_in = ST_BAL_WT;
         ST_BAL_WT:  if (div_rsp.done) state_in = ST_FLT_MK;
         ST_FLT_MK:  state_in = ST_FLT_ME;
         ST_FLT_ME:  state_in = ST_FLT_ADD;
         ST_FLT_ADD: state_in = ST_INT;
         ST_INT:     state_in = ST_VEL_MP;
         ST_VEL_MP:  state_in = ST_VEL_MI;
         ST_VEL_MI:  state_in = ST_VEL_ADD;
         ST_VEL_ADD: state_in = ST_VEL_GO;
         ST_VEL_GO:  state_in = ST_VEL_WT;
         ST_VEL_WT:  if (div_rsp.done) state_in = ST_YAW_MP;
         ST_YAW_MP:  state_in = ST_YAW_GO;
         ST_YAW_GO:  state_in = ST_YAW_WT;
         ST_YAW_WT:  if (div_rsp.done) state_in = ST_OUT;
         ST_OUT:     if (out_fire) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_BAL_MP: begin
            mul_a = MUL_A_W'(tilt_err_ff);
            mul_b = signed'({1'b0, balance_kp_ff});
         end
         ST_BAL_MD: begin
            mul_a = MUL_A_W'(pitch_rate_ff);
            mul_b = signed'({1'b0, balance_kd_ff});
         end
         ST_FLT_MK: begin
            mul_a = MUL_A_W'(filt_ff);
            mul_b = FILT_KEEP;
         end
         ST_FLT_ME: begin
            mul_a = MUL_A_W'(speed_err_ff);
            mul_b = FILT_NEW;
         end
         ST_VEL_MP: begin
            mul_a = MUL_A_W'(filt_ff);
            mul_b = signed'({1'b0, speed_kp_ff});
         end
         ST_VEL_MI: begin
            mul_a = MUL_A_W'(integ_ff);
            mul_b = signed'({1'b0, speed_ki_ff});
         end
         ST_YAW_MP: begin
            mul_a = MUL_A_W'(yaw_rate_ff);
            mul_b = signed'({1'b0, yaw_kd_ff});
         end
         default: ;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Magnitudes for the divider, sums and the integral clamp.
   assign acc_mag   = acc_ff[PROD_W-1] ? unsigned'(-acc_ff) : unsigned'(acc_ff);
   assign prod_mag  = prod_ff[PROD_W-1] ? unsigned'(-prod_ff) : unsigned'(prod_ff);
   assign filt_sum  = acc_ff + prod_ff;
   assign integ_sum = ISUM_W'(integ_ff) + ISUM_W'(filt_ff);

   always_comb begin
      if (integ_sum > INTEG_LIMIT) begin
         integ_in = INTEG_W'(INTEG_LIMIT);
      end else if (integ_sum < -INTEG_LIMIT) begin
         integ_in = INTEG_W'(-INTEG_LIMIT);
      end else begin
         integ_in = INTEG_W'(integ_sum);
      end
   end

   // The balance and speed sums drop their Q8 scale before the divide.
   always_comb begin
      div_req.start = (state_ff == ST_BAL_GO) || (state_ff == ST_VEL_GO) ||
                      (state_ff == ST_YAW_GO);
      if (state_ff == ST_YAW_GO) begin
         div_req.num = prod_mag[DIV_NUM_W-1:0];
      end else begin
         div_req.num = acc_mag[SCALE_SHIFT +: DIV_NUM_W];
      end
   end

   brmc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign quot_pos = signed'({1'b0, div_rsp.quot});
   assign quot_neg = -quot_pos;

   // Filter and integral state.
   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff  <= '0;
         integ_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_FLT_ADD: filt_ff  <= filt_sum[FILT_SHIFT +: FILT_W];
            ST_INT:     integ_ff <= integ_in;
            // The product of this cycle still sees the old integral.
            ST_VEL_MI:  if (fault_ff) integ_ff <= '0;
            default: ;
         endcase
      end
   end

   // Captured word and datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (req_fire) begin
         tilt_err_ff   <= ERR_W'(req_data.tilt_angle) - ERR_W'(balance_point_ff);
         pitch_rate_ff <= req_data.pitch_rate;
         yaw_rate_ff   <= req_data.yaw_rate;
         speed_err_ff  <= -(ERR_W'(req_data.left_count) + ERR_W'(req_data.right_count));
         fault_ff      <= (req_data.tilt_angle > TILT_LIMIT) ||
                          (req_data.tilt_angle < -TILT_LIMIT) || stop_request_ff;
      end
      unique case (state_ff)
         ST_BAL_MD:  acc_ff <= prod_ff;
         ST_BAL_ADD: acc_ff <= acc_ff + (prod_ff <<< SCALE_SHIFT);
         ST_FLT_ME:  acc_ff <= prod_ff;
         ST_VEL_MI:  acc_ff <= prod_ff;
         ST_VEL_ADD: acc_ff <= acc_ff + prod_ff;
         ST_BAL_GO:  neg_ff <= acc_ff[PROD_W-1];
         ST_VEL_GO:  neg_ff <= acc_ff[PROD_W-1];
         ST_YAW_GO:  neg_ff <= prod_ff[PROD_W-1];
         ST_BAL_WT:  if (div_rsp.done) bal_ff <= neg_ff ? quot_neg : quot_pos;
         // The speed term enters with its sign inverted.
         ST_VEL_WT: begin
            if (div_rsp.done) begin
               bal_vel_ff <= (TERM_W+1)'(bal_ff) +
                             (TERM_W+1)'(neg_ff ? quot_pos : quot_neg);
            end
         end
         ST_YAW_WT:  if (div_rsp.done) yaw_ff <= neg_ff ? quot_neg : quot_pos;
         default: ;
      endcase
   end

   // Wheel commands and the result register.
   assign left_cmd    = CMD_W'(bal_vel_ff) + CMD_W'(yaw_ff);
   assign right_cmd   = CMD_W'(bal_vel_ff) - CMD_W'(yaw_ff);
   assign left_drive  = drive_word(left_cmd, pwm_limit_ff);
   assign right_drive = drive_word(right_cmd, pwm_limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_fire) begin
         rsp_data_ff.left_magnitude  <= left_drive[MAG_W-1:0];
         rsp_data_ff.left_forward    <= left_drive[MAG_W];
         rsp_data_ff.right_magnitude <= right_drive[MAG_W-1:0];
         rsp_data_ff.right_forward   <= right_drive[MAG_W];
         rsp_data_ff.tilt_fault      <= fault_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/brmc_chk.sv -----
// ----------------------------------------------------------------------------
// Balance robot motor control: port checker
// Watches the top level's channels over time and is bound to every instance
// of the top level.
// ----------------------------------------------------------------------------
`include "balance_robot_motor_control_macros.svh"

module brmc_chk (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input brmc_pkg::brmc_rsp_type rsp_data
);
   import brmc_pkg::*;

   // A stalled result word stays offered and unchanged.
   `BRMC_ASSERT_NEXT(a_rsp_valid_hold, rsp_valid && rsp_stall, rsp_valid)
   `BRMC_ASSERT_NEXT(a_rsp_data_hold, rsp_valid && rsp_stall, $stable(rsp_data))

   // One word at a time: the block is busy right after it takes a word.
   `BRMC_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // A forward direction always comes with a non-zero duty.
   `BRMC_ASSERT_NOW(a_left_dir, rsp_valid && rsp_data.left_forward,
                    rsp_data.left_magnitude != 13'd0)
   `BRMC_ASSERT_NOW(a_right_dir, rsp_valid && rsp_data.right_forward,
                    rsp_data.right_magnitude != 13'd0)

endmodule

bind balance_robot_motor_control brmc_chk u_brmc_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
